[hw/rtl/json_array_object_splitter_unit_assert.svh]
// Assertion macros used by the splitter tracker RTL.
// Each expects clk and rst_n in scope.
`ifndef JSON_ARRAY_OBJECT_SPLITTER_UNIT_ASSERT_SVH
`define JSON_ARRAY_OBJECT_SPLITTER_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
`define JAOS_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");
`define JAOS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define JAOS_ASSERT_IMP(label, ante, cons)
`define JAOS_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[hw/rtl/jaos_pkg.sv]
package jaos_pkg;

    localparam int KEY_MAX_CHARS_DEF = 8;
    localparam int DEPTH_BITS_DEF    = 8;
    localparam int COUNT_BITS_DEF    = 16;

    localparam int CHAR_W    = 16;
    localparam int KEY_SLOTS = 8;
    localparam int LEN_W     = 4;
    localparam int CNT_OUT_W = 16;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 64;

    localparam logic [CHAR_W-1:0] CH_LBRACKET  = 16'h005B;
    localparam logic [CHAR_W-1:0] CH_RBRACKET  = 16'h005D;
    localparam logic [CHAR_W-1:0] CH_LBRACE    = 16'h007B;
    localparam logic [CHAR_W-1:0] CH_RBRACE    = 16'h007D;
    localparam logic [CHAR_W-1:0] CH_BACKSLASH = 16'h005C;
    localparam logic [CHAR_W-1:0] CH_QUOTE     = 16'h0022;

    localparam logic [1:0] REG_KEY_LENGTH     = 2'd0;
    localparam logic [1:0] REG_KEY_CHARS_LOW  = 2'd1;
    localparam logic [1:0] REG_KEY_CHARS_HIGH = 2'd2;

    typedef enum logic [4:0] {
        PH_SEARCH = 5'b00001,
        PH_SEEK   = 5'b00010,
        PH_ARRAY  = 5'b00100,
        PH_OBJECT = 5'b01000,
        PH_CLOSED = 5'b10000
    } phase_t;

    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctrl_t;

    typedef struct packed {
        logic [CHAR_W-1:0]    echo_char;
        logic                 in_object;
        logic                 object_end;
        logic                 key_found;
        logic                 array_closed;
        logic [CNT_OUT_W-1:0] object_count;
        logic                 doc_end;
    } result_t;

endpackage

[hw/rtl/jaos_if.sv]
interface jaos_text_if
    import jaos_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAR_W-1:0] text_char;
    logic              end_of_text;

    modport source (output valid, output text_char, output end_of_text, input ready);
    modport sink (input valid, input text_char, input end_of_text, output ready);
endinterface

interface jaos_result_if
    import jaos_pkg::*;
;
    logic                 valid;
    logic                 ready;
    logic [CHAR_W-1:0]    echo_char;
    logic                 in_object;
    logic                 object_end;
    logic                 key_found;
    logic                 array_closed;
    logic [CNT_OUT_W-1:0] object_count;
    logic                 doc_end;

    modport source (output valid, output echo_char, output in_object, output object_end,
                    output key_found, output array_closed, output object_count,
                    output doc_end, input ready);
    modport sink (input valid, input echo_char, input in_object, input object_end,
                  input key_found, input array_closed, input object_count,
                  input doc_end, output ready);
endinterface

[hw/rtl/json_array_object_splitter_unit.sv]
// JSON array object splitter.
// text_ch carries one UTF-16 code unit per item with end_of_text on the last
// one; result_ch returns one item per input: the echoed character, element
// object flags, key/array status and the running completed-object count.
// The key is set over the APB port: key_length at 0x00, key_chars_low at
// 0x08, key_chars_high at 0x10; write only while no item is in flight.
// Each result is formed from its input and registered in the output buffer.
// Throughput: one item per cycle while text_ch.ready is high; the match cell
// chain (one cell per window character) and the phase/depth tracker update per item.
// Output: two-entry buffer; text_ch.ready falls only once both entries hold
// results the receiver has not taken, and nothing is lost while stalled.
// Reset: key registers, window, phase, depth, string flags and count clear.
// After the end_of_text item all scan state returns to its reset values;
// the key registers are kept.
module json_array_object_splitter_unit
    import jaos_pkg::*;
#(
    parameter int KEY_MAX_CHARS = KEY_MAX_CHARS_DEF,
    parameter int DEPTH_BITS    = DEPTH_BITS_DEF,
    parameter int COUNT_BITS    = COUNT_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    jaos_text_if.sink          text_ch,
    jaos_result_if.source      result_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [APB_AW-1:0]  paddr,
    input  logic [APB_DW-1:0]  pwdata,
    output logic [APB_DW-1:0]  prdata,
    output logic               pready
);

    localparam int WIN_DEPTH = KEY_MAX_CHARS + 2;

    logic [LEN_W-1:0]                 key_length_reg;
    logic [APB_DW-1:0]                key_low_reg;
    logic [APB_DW-1:0]                key_high_reg;
    logic                             cfg_wr;
    logic [LEN_W-1:0]                 key_len;
    logic [KEY_SLOTS-1:0][CHAR_W-1:0] key_chars;

    logic                             step;
    win_ctrl_t                        win_ctrl;
    logic [WIN_DEPTH-1:0][CHAR_W-1:0] cell_in;
    logic [WIN_DEPTH-1:0][CHAR_W-1:0] cell_out;
    logic [WIN_DEPTH-1:0]             cell_hit;
    result_t                          res;

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg, main_next;
    result_t skid_reg, skid_next;
    logic    take;

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_length_reg <= '0;
            key_low_reg    <= '0;
            key_high_reg   <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:3])
                REG_KEY_LENGTH:     key_length_reg <= pwdata[LEN_W-1:0];
                REG_KEY_CHARS_LOW:  key_low_reg    <= pwdata;
                REG_KEY_CHARS_HIGH: key_high_reg   <= pwdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:3])
            REG_KEY_LENGTH:     prdata = APB_DW'(key_length_reg);
            REG_KEY_CHARS_LOW:  prdata = key_low_reg;
            REG_KEY_CHARS_HIGH: prdata = key_high_reg;
            default:            prdata = '0;
        endcase
    end

    assign key_len   = (key_length_reg > LEN_W'(KEY_MAX_CHARS)) ?
                       LEN_W'(KEY_MAX_CHARS) : key_length_reg;
    assign key_chars = {key_high_reg, key_low_reg};

    // match window: cell 0 takes the new character
    assign step = text_ch.valid && text_ch.ready;

    genvar gi;
    generate
        for (gi = 0; gi < WIN_DEPTH; gi++) begin : g_cell
            if (gi == 0) begin : g_head
                assign cell_in[gi] = text_ch.text_char;
            end else begin : g_link
                assign cell_in[gi] = cell_out[gi-1];
            end
            jaos_match_cell #(
                .CELL_INDEX (gi)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctrl      (win_ctrl),
                .din       (cell_in[gi]),
                .key_len   (key_len),
                .key_chars (key_chars),
                .dout      (cell_out[gi]),
                .hit       (cell_hit[gi])
            );
        end
    endgenerate

    jaos_tracker #(
        .DEPTH_BITS (DEPTH_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .text_char   (text_ch.text_char),
        .end_of_text (text_ch.end_of_text),
        .key_match   (&cell_hit),
        .win_ctrl    (win_ctrl),
        .result      (res)
    );

    // output buffer
    assign take          = main_valid_reg && result_ch.ready;
    assign text_ch.ready = !skid_valid_reg;

    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (take) begin
            main_valid_next = skid_valid_reg;
            main_next       = skid_reg;
            skid_valid_next = 1'b0;
        end
        if (step) begin
            if (!main_valid_next) begin
                main_valid_next = 1'b1;
                main_next       = res;
            end else begin
                skid_valid_next = 1'b1;
                skid_next       = res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign result_ch.valid        = main_valid_reg;
    assign result_ch.echo_char    = main_reg.echo_char;
    assign result_ch.in_object    = main_reg.in_object;
    assign result_ch.object_end   = main_reg.object_end;
    assign result_ch.key_found    = main_reg.key_found;
    assign result_ch.array_closed = main_reg.array_closed;
    assign result_ch.object_count = main_reg.object_count;
    assign result_ch.doc_end      = main_reg.doc_end;

endmodule

[hw/rtl/jaos_match_cell.sv]
module jaos_match_cell
    import jaos_pkg::*;
#(
    parameter int CELL_INDEX = 0
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  win_ctrl_t                        ctrl,
    input  logic [CHAR_W-1:0]                din,
    input  logic [LEN_W-1:0]                 key_len,
    input  logic [KEY_SLOTS-1:0][CHAR_W-1:0] key_chars,
    output logic [CHAR_W-1:0]                dout,
    output logic                             hit
);

    logic [CHAR_W-1:0] char_reg;
    logic [CHAR_W-1:0] char_next;
    logic [LEN_W:0]    pos;
    logic [LEN_W:0]    slot;

    // pattern position of this cell: closing quote at 0, opening quote at len+1
    assign pos  = {1'b0, key_len};
    assign slot = pos - (LEN_W + 1)'(CELL_INDEX);

    always_comb
    begin
        if (CELL_INDEX == 0) begin
            hit = (din == CH_QUOTE);
        end else if (pos + (LEN_W + 1)'(1) == (LEN_W + 1)'(CELL_INDEX)) begin
            hit = (din == CH_QUOTE);
        end else if ((LEN_W + 1)'(CELL_INDEX) <= pos) begin
            hit = (din == key_chars[slot[2:0]]);
        end else begin
            hit = 1'b1;
        end
    end

    always_comb
    begin
        char_next = char_reg;
        if (ctrl.clear) begin
            char_next = '0;
        end else if (ctrl.shift) begin
            char_next = din;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            char_reg <= '0;
        end else begin
            char_reg <= char_next;
        end
    end

    assign dout = char_reg;

endmodule

[hw/rtl/jaos_tracker.sv]
`include "json_array_object_splitter_unit_assert.svh"

module jaos_tracker
    import jaos_pkg::*;
#(
    parameter int DEPTH_BITS = DEPTH_BITS_DEF,
    parameter int COUNT_BITS = COUNT_BITS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [CHAR_W-1:0] text_char,
    input  logic              end_of_text,
    input  logic              key_match,
    output win_ctrl_t         win_ctrl,
    output result_t           result
);

    localparam logic [DEPTH_BITS-1:0] DEPTH_ONE = DEPTH_BITS'(1);
    localparam logic [DEPTH_BITS-1:0] DEPTH_MAX = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    phase_t                phase_reg, phase_next;
    logic [DEPTH_BITS-1:0] depth_reg, depth_next;
    logic                  in_str_reg, in_str_next;
    logic                  esc_reg, esc_next;
    logic [COUNT_BITS-1:0] count_reg, count_next;
    logic                  obj;
    logic                  obj_end;

    always_comb
    begin
        phase_next  = phase_reg;
        depth_next  = depth_reg;
        in_str_next = in_str_reg;
        esc_next    = esc_reg;
        count_next  = count_reg;
        obj         = 1'b0;
        obj_end     = 1'b0;
        case (phase_reg)
            PH_SEARCH:
            begin
                if (key_match) begin
                    phase_next = PH_SEEK;
                end
            end
            PH_SEEK:
            begin
                if (text_char == CH_LBRACKET) begin
                    phase_next = PH_ARRAY;
                end
            end
            PH_ARRAY:
            begin
                if (text_char == CH_RBRACKET) begin
                    phase_next = PH_CLOSED;
                end else if (text_char == CH_LBRACE) begin
                    phase_next  = PH_OBJECT;
                    depth_next  = DEPTH_ONE;
                    in_str_next = 1'b0;
                    esc_next    = 1'b0;
                    obj         = 1'b1;
                end
            end
            PH_OBJECT:
            begin
                obj = 1'b1;
                if (in_str_reg) begin
                    if (esc_reg) begin
                        esc_next = 1'b0;
                    end else if (text_char == CH_BACKSLASH) begin
                        esc_next = 1'b1;
                    end else if (text_char == CH_QUOTE) begin
                        in_str_next = 1'b0;
                    end
                end else if (text_char == CH_QUOTE) begin
                    in_str_next = 1'b1;
                end else if (text_char == CH_LBRACE) begin
                    if (depth_reg != DEPTH_MAX) begin
                        depth_next = depth_reg + DEPTH_ONE;
                    end
                end else if (text_char == CH_RBRACE) begin
                    if (depth_reg <= DEPTH_ONE) begin
                        depth_next = '0;
                        obj_end    = 1'b1;
                        phase_next = PH_ARRAY;
                        if (count_reg != COUNT_MAX) begin
                            count_next = count_reg + COUNT_BITS'(1);
                        end
                    end else begin
                        depth_next = depth_reg - DEPTH_ONE;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= PH_SEARCH;
            depth_reg  <= '0;
            in_str_reg <= 1'b0;
            esc_reg    <= 1'b0;
            count_reg  <= '0;
        end else if (step) begin
            if (end_of_text) begin
                phase_reg  <= PH_SEARCH;
                depth_reg  <= '0;
                in_str_reg <= 1'b0;
                esc_reg    <= 1'b0;
                count_reg  <= '0;
            end else begin
                phase_reg  <= phase_next;
                depth_reg  <= depth_next;
                in_str_reg <= in_str_next;
                esc_reg    <= esc_next;
                count_reg  <= count_next;
            end
        end
    end

    assign win_ctrl.shift = step && (phase_reg == PH_SEARCH);
    assign win_ctrl.clear = step && end_of_text;

    assign result.echo_char    = text_char;
    assign result.in_object    = obj;
    assign result.object_end   = obj_end;
    assign result.key_found    = (phase_next != PH_SEARCH);
    assign result.array_closed = (phase_next == PH_CLOSED);
    assign result.object_count = CNT_OUT_W'(count_next);
    assign result.doc_end      = end_of_text;

    `JAOS_ASSERT_IMP(a_esc_only_in_string, esc_reg, in_str_reg)
    `JAOS_ASSERT_IMP(a_object_has_depth, phase_reg == PH_OBJECT, depth_reg != '0)
    `JAOS_ASSERT_NEXT(a_end_clears, step && end_of_text,
                      phase_reg == PH_SEARCH && count_reg == '0 && depth_reg == '0)
    `JAOS_ASSERT_IMP(a_end_only_in_object, obj_end, phase_reg == PH_OBJECT && !in_str_reg)

endmodule
